### rtl/iosd_pkg.sv
// Package for the IR obstacle steering decider.
// Holds the channel payload types, action codes, register indexes and fixed constants.
// No dependencies.
package iosd_pkg;

  localparam int SMP_W  = 12;
  localparam int DUTY_W = 16;
  localparam int QUOT_W = 15;

  // Distance numerator pre-divided by the sensor scale:
  // floor(floor(a/b)/c) equals floor(a/(b*c)).
  localparam logic [QUOT_W-1:0] DIST_QUOT = QUOT_W'(5324800 / 165);
  localparam logic [DUTY_W-1:0] DIST_MAX  = 16'hFFFF;
  localparam logic [7:0]        SPEED_GAIN   = 8'd225;
  localparam logic [10:0]       SPEED_OFFSET = 11'd2000;
  localparam logic [DUTY_W-1:0] STOP_DUTY    = 16'd1;

  localparam logic [2:0] ACT_STOP  = 3'd0;
  localparam logic [2:0] ACT_SPIN  = 3'd1;
  localparam logic [2:0] ACT_LEFT  = 3'd2;
  localparam logic [2:0] ACT_RIGHT = 3'd3;
  localparam logic [2:0] ACT_FWD   = 3'd4;

  localparam logic [1:0] CFG_SPIN_THR = 2'd0;
  localparam logic [1:0] CFG_TURN_THR = 2'd1;
  localparam logic [1:0] CFG_FULL     = 2'd2;
  localparam logic [1:0] CFG_SLOW     = 2'd3;

  localparam logic [1:0] SMP_RIGHT  = 2'd0;
  localparam logic [1:0] SMP_MIDDLE = 2'd1;
  localparam logic [1:0] SMP_LEFT   = 2'd2;

  typedef struct packed {
    logic             button_pressed;
    logic [SMP_W-1:0] sensor_right;
    logic [SMP_W-1:0] sensor_middle;
    logic [SMP_W-1:0] sensor_left;
  } iosd_in_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic              bridge_enable;
    logic              motor_b_reverse;
  } iosd_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iosd_div_stat_t;

endpackage

### rtl/iosd_if.sv
// Valid/ready channel interfaces for the IR obstacle steering decider.
// Depends on iosd_pkg for the payload types.
interface iosd_in_if import iosd_pkg::*; ();
  logic     valid;
  logic     ready;
  iosd_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface iosd_out_if import iosd_pkg::*; ();
  logic      valid;
  logic      ready;
  iosd_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/iosd_div.sv
// Shared radix-2 restoring divider: the distance constant over one sensor sample.
// One quotient bit per cycle; depends on iosd_pkg.
module iosd_div import iosd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SMP_W-1:0]  divisor,
  output iosd_div_stat_t    stat,
  output logic [QUOT_W-1:0] quotient
);

  logic [QUOT_W-1:0] work_r, work_nxt;
  logic [SMP_W-1:0]  rem_r, rem_nxt;
  logic [SMP_W-1:0]  dvs_r;
  logic [3:0]        cnt_r;
  logic              busy_r;
  logic [SMP_W:0]    trial;
  logic              ge;

  // The dividend shifts out of the top of work_r while quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem_r, work_r[QUOT_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    rem_nxt  = ge ? SMP_W'(trial - {1'b0, dvs_r}) : trial[SMP_W-1:0];
    work_nxt = {work_r[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'(QUOT_W - 1);
      work_r <= DIST_QUOT;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == 4'd0);
  assign quotient  = work_r;

endmodule

### rtl/ir_obstacle_steering_decider_unit.sv
// Top level of the IR obstacle steering decider: sequencer, speed step and decision.
// Depends on iosd_pkg, iosd_if and iosd_div.
//
// Each accepted transaction toggles the run flag when its button bit is set and yields
// exactly one result transaction. A stopped transaction goes straight to the output
// register. A running one passes its three samples one after another through the
// single shared divider, each loaded, divided and scaled to a speed, then loads the
// output register once it is free. The input is not ready while a transaction is in
// work; the output register lets a new transaction enter while the previous result
// still waits to be taken. Configuration registers take effect on the next transaction
// if the user writes them between transactions; the block does not enforce this.
module ir_obstacle_steering_decider_unit import iosd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  iosd_in_if.sink           in_ch,
  iosd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DUTY_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_SPEED,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [DUTY_W-1:0] spin_thr_r, turn_thr_r, full_duty_r, slow_duty_r;
  logic              run_r;
  logic              b_rev_r;
  logic [SMP_W-1:0]  smp_r [3];
  logic [DUTY_W-1:0] spd_r [3];
  logic [1:0]        idx_r;
  logic              out_valid_r;
  iosd_out_t         out_r;

  iosd_div_stat_t    div_stat;
  logic [QUOT_W-1:0] quot;
  logic              div_start;
  logic [SMP_W-1:0]  cur_smp;
  logic [DUTY_W-1:0] dist_val;
  logic [23:0]       spd_full;
  logic [DUTY_W-1:0] spd_nxt;
  logic              in_acc;
  logic              run_nxt;
  logic              do_spin, do_left, do_right;
  iosd_out_t         res;
  logic              b_rev_nxt;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign run_nxt   = run_r ^ in_ch.data.button_pressed;
  assign cur_smp   = smp_r[idx_r];
  assign div_start = (state_r == S_START);

  iosd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (cur_smp),
    .stat     (div_stat),
    .quotient (quot)
  );

  // A zero sample means the farthest distance, so the speed saturates.
  always_comb begin
    dist_val = (cur_smp == '0) ? DIST_MAX : {1'b0, quot};
    spd_full = 24'(dist_val) * 24'(SPEED_GAIN) + 24'(SPEED_OFFSET);
    spd_nxt  = (spd_full > {8'd0, full_duty_r}) ? full_duty_r : spd_full[DUTY_W-1:0];
  end

  // Left wins a tie when both side conditions hold.
  always_comb begin
    do_spin  = spd_r[SMP_MIDDLE] <= spin_thr_r;
    do_left  = (spd_r[SMP_RIGHT] <= turn_thr_r) && (spd_r[SMP_LEFT] >= spd_r[SMP_RIGHT]);
    do_right = (spd_r[SMP_LEFT] <= turn_thr_r) && (spd_r[SMP_RIGHT] >= spd_r[SMP_LEFT]);
    res.bridge_enable = run_r;
    res.duty_a        = full_duty_r;
    res.duty_b        = full_duty_r;
    b_rev_nxt         = 1'b0;
    if (!run_r) begin
      res.action = ACT_STOP;
      res.duty_a = STOP_DUTY;
      res.duty_b = STOP_DUTY;
      b_rev_nxt  = b_rev_r;
    end else if (do_spin) begin
      res.action = ACT_SPIN;
      b_rev_nxt  = 1'b1;
    end else if (do_left) begin
      res.action = ACT_LEFT;
      res.duty_b = slow_duty_r;
    end else if (do_right) begin
      res.action = ACT_RIGHT;
      res.duty_a = slow_duty_r;
    end else begin
      res.action = ACT_FWD;
    end
    res.motor_b_reverse = b_rev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      b_rev_r     <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= SMP_RIGHT;
      spin_thr_r  <= 16'd4500;
      turn_thr_r  <= 16'd5500;
      full_duty_r <= 16'd18750;
      slow_duty_r <= 16'd1000;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPIN_THR: spin_thr_r  <= cfg_data;
          CFG_TURN_THR: turn_thr_r  <= cfg_data;
          CFG_FULL:     full_duty_r <= cfg_data;
          CFG_SLOW:     slow_duty_r <= cfg_data;
          default:      ;
        endcase
      end

      // In S_OUT the output register is reloaded instead of cleared.
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            run_r             <= run_nxt;
            smp_r[SMP_RIGHT]  <= in_ch.data.sensor_right;
            smp_r[SMP_MIDDLE] <= in_ch.data.sensor_middle;
            smp_r[SMP_LEFT]   <= in_ch.data.sensor_left;
            idx_r             <= SMP_RIGHT;
            state_r           <= run_nxt ? S_START : S_OUT;
          end
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_SPEED;
          end
        end
        S_SPEED: begin
          spd_r[idx_r] <= spd_nxt;
          if (idx_r == SMP_LEFT) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_START;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            b_rev_r     <= b_rev_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

### rtl/iosd_checker.sv
// Port-level checker for the IR obstacle steering decider, bound to the top level.
// Depends on iosd_pkg and ir_obstacle_steering_decider_unit.
module iosd_checker import iosd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input iosd_out_t out_data
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  a_stop_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_STOP) |->
      !out_data.bridge_enable && (out_data.duty_a == STOP_DUTY) &&
      (out_data.duty_b == STOP_DUTY))
    else $error("stopped result with bridge on or wrong duties");

  a_spin_reverse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_SPIN) |->
      out_data.motor_b_reverse && out_data.bridge_enable)
    else $error("spin result without motor B reversed");

  a_run_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.action == ACT_LEFT) || (out_data.action == ACT_RIGHT) ||
      (out_data.action == ACT_FWD)) |->
      !out_data.motor_b_reverse && out_data.bridge_enable)
    else $error("turn or forward result with motor B reversed or bridge off");

endmodule

bind ir_obstacle_steering_decider_unit iosd_checker u_iosd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
